[rtl/core/fpa_pkg.sv]
// shared types, constants and helpers for the q24.8 fixed-point alu
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  // dividend width of the long division: magnitude shifted by the fraction bits
  localparam int DW  = 32 + FRAC_BITS;
  // decode, multiply, one stage per quotient bit, final rounding
  localparam int NST = DW + 3;

  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_GT      = 4'd4,
    CMD_LT      = 4'd5,
    CMD_GE      = 4'd6,
    CMD_LE      = 4'd7,
    CMD_EQ      = 4'd8,
    CMD_NE      = 4'd9,
    CMD_MIN     = 4'd10,
    CMD_MAX     = 4'd11,
    CMD_INC     = 4'd12,
    CMD_DEC     = 4'd13,
    CMD_TOINT   = 4'd14,
    CMD_FROMINT = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // status travels as plain bits so it can be loaded from {status, value} pairs
  typedef struct packed {
    cmd_t          cmd;
    logic          neg;
    logic [31:0]   val;
    logic          cmp;
    logic [1:0]    st;
    logic [31:0]   maga;
    logic [31:0]   magb;
    logic [DW-1:0] dvd;
    logic [31:0]   rem;
    logic [DW-1:0] quo;
    logic [63:0]   mq;
    logic          rnd;
    logic          dz;
  } stage_t;

  // saturate a sign and magnitude into a 32-bit value, returns {status, value}
  function automatic logic [33:0] sat_mag(input logic neg, input logic [64:0] mag);
    logic [31:0] v;
    status_t     s;
    s = ST_OK;
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        v = 32'h8000_0000;
        s = ST_OVF;
      end else begin
        v = ~mag[31:0] + 32'd1;
      end
    end else begin
      if (mag > 65'h0_7FFF_FFFF) begin
        v = 32'h7FFF_FFFF;
        s = ST_OVF;
      end else begin
        v = mag[31:0];
      end
    end
    return {s, v};
  endfunction

  // saturate a 33-bit signed sum, returns {status, value}
  function automatic logic [33:0] sat33(input logic [32:0] sum);
    logic [31:0] v;
    status_t     s;
    s = ST_OK;
    v = sum[31:0];
    if (sum[32] != sum[31]) begin
      s = ST_OVF;
      v = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return {s, v};
  endfunction

endpackage

[rtl/core/fixed_point_alu_q24_8.sv]
// signed q24.8 fixed-point alu, fully pipelined with a bit-per-stage divider
// every command passes through all NST stages, whatever its kind
// throughput: one beat per cycle while the output is not stalled; every stage has its own valid and ready,
// so bubbles close up and a stalled output still lets earlier stages fill
// the divider takes one quotient bit per stage over 32 + FRAC_BITS stages
// reset: synchronous, clears all stage valid bits; payload is not reset
module fixed_point_alu_q24_8 import fpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value_out,
  output logic               compare_true,
  output logic [1:0]         status
);

  stage_t pipe [NST];
  stage_t nxt  [NST];
  logic   vld  [NST];
  logic   rdy  [NST];
  stage_t dec;

  fpa_decode u_dec (
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .stage     (dec)
  );

  // per-stage handshake: a stage loads when empty or when it is draining
  assign rdy[NST-1] = !vld[NST-1] || out_ready;
  genvar i;
  generate
    for (i = 0; i < NST - 1; i++) begin : g_rdy
      assign rdy[i] = !vld[i] || rdy[i+1];
    end
  endgenerate
  assign in_ready = rdy[0];

  // stage transforms
  assign nxt[0] = dec;

  always_comb begin
    nxt[1]    = pipe[0];
    nxt[1].mq = 64'(pipe[0].maga) * 64'(pipe[0].magb);
  end

  generate
    for (i = 2; i < NST - 1; i++) begin : g_div
      logic [32:0] rsh;
      assign rsh = {pipe[i-1].rem, pipe[i-1].dvd[DW-1]};
      // one restoring division step, plus the product shift in the first one
      always_comb begin
        nxt[i]     = pipe[i-1];
        nxt[i].dvd = {pipe[i-1].dvd[DW-2:0], 1'b0};
        if (rsh >= {1'b0, pipe[i-1].magb}) begin
          nxt[i].rem = 32'(rsh - {1'b0, pipe[i-1].magb});
          nxt[i].quo = {pipe[i-1].quo[DW-2:0], 1'b1};
        end else begin
          nxt[i].rem = rsh[31:0];
          nxt[i].quo = {pipe[i-1].quo[DW-2:0], 1'b0};
        end
        if (i == 2 && pipe[i-1].cmd == CMD_MUL) begin
          nxt[i].mq  = pipe[i-1].mq >> FRAC_BITS;
          nxt[i].rnd = pipe[i-1].mq[FRAC_BITS-1];
        end
      end
    end
  endgenerate

  // final rounding and saturation for mul and div
  always_comb begin
    stage_t      p;
    logic [64:0] mag;
    logic        rb;
    p      = pipe[NST-2];
    nxt[NST-1] = p;
    rb     = ({p.rem, 1'b0} >= {1'b0, p.magb});
    mag    = '0;
    if (p.cmd == CMD_MUL) begin
      mag = 65'(p.mq) + 65'(p.rnd);
      {nxt[NST-1].st, nxt[NST-1].val} = sat_mag(p.neg, mag);
    end else if (p.cmd == CMD_DIV) begin
      if (p.dz) begin
        nxt[NST-1].val = '0;
        nxt[NST-1].st  = ST_DZ;
      end else begin
        mag = 65'(p.quo) + 65'(rb);
        {nxt[NST-1].st, nxt[NST-1].val} = sat_mag(p.neg, mag);
      end
    end
  end

  // stage registers
  generate
    for (i = 0; i < NST; i++) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (rdy[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[i]) begin
          pipe[i] <= nxt[i];
        end
      end
    end
  endgenerate

  assign out_valid    = vld[NST-1];
  assign value_out    = pipe[NST-1].val;
  assign compare_true = pipe[NST-1].cmp;
  assign status       = pipe[NST-1].st;

  // a comparison beat carries a zero value and ok status
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> value_out == 32'd0 && status == ST_OK)
    else $error("comparison beat with nonzero value or status");

  // divide by zero always yields zero
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DZ |-> value_out == 32'd0 && !compare_true)
    else $error("divide by zero beat with nonzero value");

  // an overflow result is one of the two saturation limits
  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVF |->
      value_out == 32'h7FFF_FFFF || value_out == 32'h8000_0000)
    else $error("overflow beat not saturated");

  // a stalled output beat is not overwritten by the pipeline
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(status))
    else $error("stalled result changed");

endmodule

[rtl/core/fpa_decode.sv]
// first stage logic: simple operations finish here, mul and div are prepared
module fpa_decode import fpa_pkg::*; (
  input  logic [3:0]   cmd,
  input  logic [31:0]  operand_a,
  input  logic [31:0]  operand_b,
  output stage_t       stage
);

  logic [31:0] maga;
  logic [31:0] magb;
  logic [31:0] qt;
  logic        lt_ab;
  logic        eq_ab;

  assign maga  = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
  assign magb  = operand_b[31] ? (~operand_b + 32'd1) : operand_b;
  assign lt_ab = $signed(operand_a) < $signed(operand_b);
  assign eq_ab = operand_a == operand_b;
  assign qt    = maga >> FRAC_BITS;

  // per-command result for the operations that finish in this stage
  always_comb begin
    stage      = '0;
    stage.cmd  = cmd_t'(cmd);
    stage.neg  = operand_a[31] ^ operand_b[31];
    stage.maga = maga;
    stage.magb = magb;
    stage.dvd  = {maga, {FRAC_BITS{1'b0}}};
    stage.dz   = operand_b == 32'd0;
    stage.st   = ST_OK;
    case (cmd_t'(cmd))
      CMD_ADD: {stage.st, stage.val} =
        sat33({operand_a[31], operand_a} + {operand_b[31], operand_b});
      CMD_SUB: {stage.st, stage.val} =
        sat33({operand_a[31], operand_a} - {operand_b[31], operand_b});
      CMD_GT:  stage.cmp = !lt_ab && !eq_ab;
      CMD_LT:  stage.cmp = lt_ab;
      CMD_GE:  stage.cmp = !lt_ab;
      CMD_LE:  stage.cmp = lt_ab || eq_ab;
      CMD_EQ:  stage.cmp = eq_ab;
      CMD_NE:  stage.cmp = !eq_ab;
      CMD_MIN: stage.val = (lt_ab || eq_ab) ? operand_a : operand_b;
      CMD_MAX: stage.val = !lt_ab ? operand_a : operand_b;
      CMD_INC: {stage.st, stage.val} = sat33({operand_a[31], operand_a} + 33'd1);
      CMD_DEC: {stage.st, stage.val} = sat33({operand_a[31], operand_a} - 33'd1);
      CMD_TOINT: stage.val = operand_a[31] ? (~qt + 32'd1) : qt;
      CMD_FROMINT: {stage.st, stage.val} =
        sat_mag(operand_a[31], 65'(maga) << FRAC_BITS);
      default: ;
    endcase
  end

endmodule

[tb/sv/tb_fixed_point_alu_q24_8.sv]
// testbench for the q24.8 fixed-point alu: directed and random beats checked against a predictor
module tb_fixed_point_alu_q24_8;
  import fpa_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  st;
  } alu_result_t;

  // scoreboard: predicts each accepted command and checks results in order
  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function automatic logic [31:0] clamp(longint v, ref logic [1:0] st);
      if (v > 64'sd2147483647) begin
        st = ST_OVF;
        return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        st = ST_OVF;
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    function automatic alu_result_t compute(cmd_t c, logic signed [31:0] a_raw,
                                            logic signed [31:0] b_raw);
      alu_result_t r;
      longint a, b, q;
      logic [63:0] m, den, rm;
      logic neg;
      a = a_raw;
      b = b_raw;
      r.value = '0;
      r.cmp = 1'b0;
      r.st = ST_OK;
      neg = (a < 0) != (b < 0);
      case (c)
        CMD_ADD: r.value = clamp(a + b, r.st);
        CMD_SUB: r.value = clamp(a - b, r.st);
        CMD_MUL: begin
          m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
          q = (m >> FRAC_BITS) + ((m >> (FRAC_BITS - 1)) & 1);
          r.value = clamp(neg ? -q : q, r.st);
        end
        CMD_DIV: begin
          if (b == 0) begin
            r.st = ST_DZ;
          end else begin
            m = (a < 0 ? -a : a) << FRAC_BITS;
            den = b < 0 ? -b : b;
            q = m / den;
            rm = m % den;
            if (2 * rm >= den) q++;
            r.value = clamp(neg ? -q : q, r.st);
          end
        end
        CMD_GT: r.cmp = a > b;
        CMD_LT: r.cmp = a < b;
        CMD_GE: r.cmp = a >= b;
        CMD_LE: r.cmp = a <= b;
        CMD_EQ: r.cmp = a == b;
        CMD_NE: r.cmp = a != b;
        CMD_MIN: r.value = clamp(a <= b ? a : b, r.st);
        CMD_MAX: r.value = clamp(a >= b ? a : b, r.st);
        CMD_INC: r.value = clamp(a + 1, r.st);
        CMD_DEC: r.value = clamp(a - 1, r.st);
        CMD_TOINT: begin
          q = (a < 0 ? -a : a) >> FRAC_BITS;
          r.value = clamp(a < 0 ? -q : q, r.st);
        end
        default: begin
          q = (a < 0 ? -a : a) << FRAC_BITS;
          r.value = clamp(a < 0 ? -q : q, r.st);
        end
      endcase
      return r;
    endfunction

    function void note_command(cmd_t c, logic signed [31:0] a, logic signed [31:0] b);
      pending.push_back(compute(c, a, b));
    endfunction

    function void check_result(logic [31:0] v, logic cmp, logic [1:0] st);
      alu_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending: value %h", v);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) begin
        $error("value_out expected %h actual %h", e.value, v);
        errors++;
      end
      if (cmp !== e.cmp) begin
        $error("compare_true expected %b actual %b", e.cmp, cmp);
        errors++;
      end
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         cmd = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] value_out;
  logic               compare_true;
  logic [1:0]         status;

  alu_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  fixed_point_alu_q24_8 dut (.*);

  always #2 clk = ~clk;

  // monitor: note accepted commands, check accepted results
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_command(cmd_t'(cmd), operand_a, operand_b);
    if (!rst && out_valid && out_ready) sb.check_result(value_out, compare_true, status);
  end

  // receiver stalls at random
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_beat(cmd_t c, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom_range(4096) - 2048;
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      3: return $signed($urandom_range(65535)) <<< $urandom_range(16);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    cmd_t c;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      c = cmd_t'($urandom_range(15));
      send_beat(c, rand_operand(), ($urandom_range(15) == 0) ? 32'd0 : rand_operand());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, saturation, divide by zero, ties
    send_beat(CMD_ADD, 32'h7FFF_FFFF, 32'd1);
    send_beat(CMD_SUB, 32'h8000_0000, 32'd1);
    send_beat(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(CMD_MUL, 32'h0000_0180, 32'hFFFF_FF80);
    send_beat(CMD_MUL, 32'd1, 32'd128);
    send_beat(CMD_DIV, 32'h0000_0100, 32'd0);
    send_beat(CMD_DIV, 32'h8000_0000, 32'h0000_0080);
    send_beat(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_beat(CMD_DIV, 32'h0000_0100, 32'h0000_0300);
    send_beat(CMD_GT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(CMD_LT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(CMD_GE, 32'd5, 32'd5);
    send_beat(CMD_LE, 32'd5, 32'd4);
    send_beat(CMD_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_NE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_MIN, 32'd7, 32'd7);
    send_beat(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(CMD_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_DEC, 32'h8000_0000, 32'd0);
    send_beat(CMD_TOINT, 32'hFFFF_FE80, 32'd0);
    send_beat(CMD_TOINT, 32'h8000_0000, 32'd0);
    send_beat(CMD_FROMINT, 32'h0080_0000, 32'd0);
    send_beat(CMD_FROMINT, 32'hFF7F_FFFF, 32'd0);
    send_beat(CMD_FROMINT, 32'h007F_FFFF, 32'd0);
    // sender holds off until everything has drained
    drain();

    random_phase(100, 0, 0);
    random_phase(100, 48, 0);
    random_phase(100, 0, 48);
    drain();
    random_phase(100, 37, 37);
    drain();
    recv_stall_pct = 0;
    repeat (NST + 10) @(negedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS fixed_point_alu_q24_8");
    end else begin
      $display("FAIL fixed_point_alu_q24_8");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #400000;
    $display("FAIL fixed_point_alu_q24_8");
    $finish;
  end
endmodule
